// ===== sv/reversible_deque_engine_assert.svh =====
// Assertion macros used by the deque engine checker.
`ifndef REVERSIBLE_DEQUE_ENGINE_ASSERT_SVH
`define REVERSIBLE_DEQUE_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RDE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rde_pkg.sv =====
// Shared constants, codes and control types of the deque engine.
package rde_pkg;

  // Default store depth
  localparam int DEPTH_DEFAULT = 1024;

  localparam int WORD_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;

  // Opcodes
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_REVERSE    = 3'd4;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_item;  // capture opcode and word
    logic do_pop;     // read the end entry, move pointers
    logic do_push;    // write the end entry, move pointers
    logic do_rev;     // toggle the reversal flag
    logic rep_empty;  // report empty status
    logic rep_full;   // report full status
    logic load_word;  // report popped word
  } rde_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic op_pop;
    logic op_push;
    logic op_rev;
    logic empty;
    logic full;
  } rde_stat_t;

endpackage

// ===== sv/rde_dp.sv =====
// Datapath: entry store, head pointer, fill count, reversal flag, result registers.
module rde_dp #(
  parameter int DEPTH = rde_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rde_pkg::rde_cmd_t                   cmd,
  output rde_pkg::rde_stat_t                  stat,
  input  logic [rde_pkg::OP_W-1:0]            opcode,
  input  logic signed [rde_pkg::WORD_W-1:0]   push_value,
  output logic                                strobe,
  output logic signed [rde_pkg::WORD_W-1:0]   pop_value,
  output logic [rde_pkg::ST_W-1:0]            status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST   = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTHX = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULLC  = CW'(DEPTH);

  // Captured item
  logic [rde_pkg::OP_W-1:0]   op_q;
  logic [rde_pkg::WORD_W-1:0] val_q;

  // Queue state
  logic [AW-1:0] head;
  logic [CW-1:0] fill;
  logic          rev;

  logic [rde_pkg::WORD_W-1:0] mem [DEPTH];
  logic [rde_pkg::WORD_W-1:0] rd_data;

  logic          at_front;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] head_dec;
  logic [AW:0]   sum;
  logic [AW:0]   sum_m1;
  logic [AW-1:0] back_addr;
  logic [AW-1:0] tail_addr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q  <= opcode;
      val_q <= push_value;
    end
  end

  // Decode for the controller
  always_comb begin
    stat.op_pop  = (op_q == rde_pkg::OP_POP_BACK)  || (op_q == rde_pkg::OP_POP_FRONT);
    stat.op_push = (op_q == rde_pkg::OP_PUSH_BACK) || (op_q == rde_pkg::OP_PUSH_FRONT);
    stat.op_rev  = (op_q == rde_pkg::OP_REVERSE);
    stat.empty   = (fill == '0);
    stat.full    = (fill == FULLC);
  end

  // Physical end selection: odd opcodes name the logical front
  assign at_front = op_q[0] ^ rev;

  // Circular address arithmetic, sums stay below twice the depth
  always_comb begin
    head_inc  = (head == LAST) ? '0 : head + AW'(1);
    head_dec  = (head == '0) ? LAST : head - AW'(1);
    sum       = {1'b0, head} + (AW + 1)'(fill);
    sum_m1    = sum - (AW + 1)'(1);
    back_addr = (sum >= DEPTHX) ? AW'(sum - DEPTHX) : sum[AW-1:0];
    tail_addr = (sum_m1 >= DEPTHX) ? AW'(sum_m1 - DEPTHX) : sum_m1[AW-1:0];
    wr_addr   = at_front ? head_dec : back_addr;
    rd_addr   = at_front ? head : tail_addr;
  end

  // Entry store
  always_ff @(posedge clk) begin
    if (cmd.do_push) begin
      mem[wr_addr] <= val_q;
    end
    if (cmd.do_pop) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Pointer, count and flag
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
      rev  <= 1'b0;
    end else begin
      if (cmd.do_pop) begin
        fill <= fill - CW'(1);
        if (at_front) head <= head_inc;
      end
      if (cmd.do_push) begin
        fill <= fill + CW'(1);
        if (at_front) head <= head_dec;
      end
      if (cmd.do_rev) rev <= ~rev;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.rep_empty | cmd.rep_full | cmd.load_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      pop_value <= rd_data;
      status    <= rde_pkg::ST_OK;
    end else if (cmd.rep_empty) begin
      pop_value <= '0;
      status    <= rde_pkg::ST_EMPTY;
    end else if (cmd.rep_full) begin
      pop_value <= '0;
      status    <= rde_pkg::ST_FULL;
    end
  end

endmodule

// ===== sv/rde_ctrl.sv =====
// Controller: sequences capture, execute and memory read of one item.
module rde_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  rde_pkg::rde_stat_t stat,
  output rde_pkg::rde_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        if (stat.op_pop) begin
          if (stat.empty) begin
            cmd.rep_empty = 1'b1;
          end else begin
            cmd.do_pop = 1'b1;
            state_next = S_READ;
          end
        end else if (stat.op_push) begin
          if (stat.full) cmd.rep_full = 1'b1;
          else           cmd.do_push  = 1'b1;
        end else if (stat.op_rev) begin
          cmd.do_rev = 1'b1;
        end
      end
      S_READ: begin
        // registered read data is ready
        cmd.load_word = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/reversible_deque_engine.sv =====
// Double-ended queue with reversal flag: top level joining controller and datapath.
// An item is taken when start is high while busy is low; busy then stays high for
// the rest of the item. A push, a reverse, an unused opcode, or a pop or push that
// only reports empty or full passes through capture and execute; a pop that returns
// a word adds a further step, the registered read of the single-port entry store.
// A result appears on pop_value and status with strobe high for exactly one
// cycle, the cycle after the item's last step, and must be taken then: there is no
// way to hold it. The next item may be started in that same cycle. The store holds
// DEPTH words and needs no clearing after reset; entries are only read once written.
module reversible_deque_engine #(
  parameter int DEPTH = rde_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [rde_pkg::OP_W-1:0]          opcode,
  input  logic signed [rde_pkg::WORD_W-1:0] push_value,
  output logic                              strobe,
  output logic signed [rde_pkg::WORD_W-1:0] pop_value,
  output logic [rde_pkg::ST_W-1:0]          status
);

  rde_pkg::rde_cmd_t  cmd;
  rde_pkg::rde_stat_t stat;

  rde_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  rde_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .opcode     (opcode),
    .push_value (push_value),
    .strobe     (strobe),
    .pop_value  (pop_value),
    .status     (status)
  );

endmodule

// ===== sv/rde_checker.sv =====
// Port-level checker for the deque engine, bound to the top level.
`include "reversible_deque_engine_assert.svh"

module rde_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              strobe,
  input logic signed [rde_pkg::WORD_W-1:0] pop_value,
  input logic [rde_pkg::ST_W-1:0]          status
);

  // A non-ok result carries a zero word
  `RDE_ASSERT_NOW(a_zero_word, clk, rst, strobe && (status != rde_pkg::ST_OK), pop_value == '0, "non-ok result with nonzero word")

  // Only defined status codes are reported
  `RDE_ASSERT_NOW(a_status_code, clk, rst, strobe, (status == rde_pkg::ST_OK) || (status == rde_pkg::ST_EMPTY) || (status == rde_pkg::ST_FULL), "undefined status code")

  // An accepted transfer keeps the engine busy next cycle
  `RDE_ASSERT_NEXT(a_busy_after_start, clk, rst, start && !busy, busy, "engine not busy after accepted transfer")

  // Each item passes through capture and execute, so results never come back to back
  `RDE_ASSERT_NEXT(a_no_double_strobe, clk, rst, strobe, !strobe, "two results in consecutive cycles")

  // A result only follows a busy cycle
  `RDE_ASSERT_NOW(a_strobe_after_busy, clk, rst, strobe, $past(busy), "result without a preceding item")

endmodule

bind reversible_deque_engine rde_checker u_rde_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for the reversible deque engine.
module testbench;

  localparam int DEPTH = rde_pkg::DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [rde_pkg::WORD_W-1:0] word;
    logic [rde_pkg::ST_W-1:0]          code;
  } deque_reply_t;

  logic                              clk;
  logic                              rst = 1'b1;
  logic                              start = 1'b0;
  logic [rde_pkg::OP_W-1:0]          opcode = rde_pkg::OP_REVERSE;
  logic signed [rde_pkg::WORD_W-1:0] push_value = '0;
  logic                              busy;
  logic                              strobe;
  logic signed [rde_pkg::WORD_W-1:0] pop_value;
  logic [rde_pkg::ST_W-1:0]          status;

  // Predicted deque contents and pointers
  logic signed [rde_pkg::WORD_W-1:0] model_store [DEPTH];
  int                                model_head = 0;
  int                                model_fill = 0;
  bit                                model_rev = 1'b0;

  deque_reply_t pending_replies[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  bit           steady = 1'b0;  // suppresses random sender gaps

  reversible_deque_engine #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .push_value(push_value),
    .strobe(strobe),
    .pop_value(pop_value),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one operation to the predicted deque; returns 1 when it yields a reply
  function automatic bit apply_deque_op(input logic [rde_pkg::OP_W-1:0] op,
                                        input logic signed [rde_pkg::WORD_W-1:0] val,
                                        output deque_reply_t reply);
    bit at_front;
    reply.word = '0;
    reply.code = rde_pkg::ST_OK;
    case (op)
      rde_pkg::OP_POP_BACK, rde_pkg::OP_POP_FRONT: begin
        if (model_fill == 0) begin
          reply.code = rde_pkg::ST_EMPTY;
          return 1'b1;
        end
        at_front = (op == rde_pkg::OP_POP_FRONT) != model_rev;
        if (at_front) begin
          reply.word = model_store[model_head];
          model_head = (model_head + 1) % DEPTH;
        end else begin
          reply.word = model_store[(model_head + model_fill - 1) % DEPTH];
        end
        model_fill--;
        return 1'b1;
      end
      rde_pkg::OP_PUSH_BACK, rde_pkg::OP_PUSH_FRONT: begin
        if (model_fill >= DEPTH) begin
          reply.code = rde_pkg::ST_FULL;
          return 1'b1;
        end
        at_front = (op == rde_pkg::OP_PUSH_FRONT) != model_rev;
        if (at_front) begin
          model_head = (model_head + DEPTH - 1) % DEPTH;
          model_store[model_head] = val;
        end else begin
          model_store[(model_head + model_fill) % DEPTH] = val;
        end
        model_fill++;
        return 1'b0;
      end
      rde_pkg::OP_REVERSE: begin
        model_rev = !model_rev;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  // Present one item, wait for its transfer, then record the predicted reply
  task automatic send_item(input logic [rde_pkg::OP_W-1:0] op,
                           input logic signed [rde_pkg::WORD_W-1:0] val);
    deque_reply_t reply;
    if (!steady && $urandom_range(99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    push_value <= val;
    do @(posedge clk); while (busy);
    if (apply_deque_op(op, val, reply)) pending_replies.insert(pending_replies.size(), reply);
  endtask

  // Stop sending until every predicted reply has come back, then let the block settle
  task automatic hold_until_drained();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [rde_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(15))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [rde_pkg::OP_W-1:0] pick_push();
    return $urandom_range(1) ? rde_pkg::OP_PUSH_FRONT : rde_pkg::OP_PUSH_BACK;
  endfunction

  function automatic logic [rde_pkg::OP_W-1:0] pick_pop();
    return $urandom_range(1) ? rde_pkg::OP_POP_FRONT : rde_pkg::OP_POP_BACK;
  endfunction

  // Pops, reverses and unused opcodes on an empty deque
  task automatic test_empty_queue();
    send_item(rde_pkg::OP_POP_BACK, 32'sh1234_5678);
    send_item(rde_pkg::OP_POP_FRONT, -1);
    send_item(3'd5, 32'sh7FFF_FFFF);
    send_item(3'd6, 32'sh8000_0000);
    send_item(3'd7, -1);
    send_item(rde_pkg::OP_REVERSE, '0);
    send_item(rde_pkg::OP_POP_FRONT, '0);
    send_item(rde_pkg::OP_REVERSE, -1);
    hold_until_drained();
  endtask

  // Ordering at both ends, with and without the reversal flag
  task automatic test_end_order();
    send_item(rde_pkg::OP_PUSH_BACK, 32'sh7FFF_FFFF);
    send_item(rde_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
    send_item(rde_pkg::OP_PUSH_BACK, -1);
    send_item(rde_pkg::OP_PUSH_FRONT, '0);
    send_item(rde_pkg::OP_PUSH_BACK, 32'sh0000_0001);
    send_item(rde_pkg::OP_POP_FRONT, '0);
    send_item(rde_pkg::OP_POP_BACK, '0);
    send_item(rde_pkg::OP_REVERSE, '0);
    send_item(rde_pkg::OP_POP_FRONT, -1);
    send_item(rde_pkg::OP_PUSH_FRONT, 32'sh5555_5555);
    send_item(rde_pkg::OP_PUSH_BACK, 32'shAAAA_AAAA);
    send_item(3'd5, 32'sh0F0F_0F0F);
    send_item(rde_pkg::OP_POP_BACK, '0);
    send_item(rde_pkg::OP_REVERSE, '0);
    send_item(rde_pkg::OP_POP_BACK, '0);
    send_item(rde_pkg::OP_POP_FRONT, '0);
    send_item(rde_pkg::OP_POP_FRONT, '0);
    hold_until_drained();
  endtask

  // Fill to capacity, then push on full at both ends in both orientations
  task automatic test_full_store();
    steady = 1'b1;
    while (model_fill < DEPTH) begin
      if ($urandom_range(63) == 0) send_item(rde_pkg::OP_REVERSE, pick_word());
      else send_item(pick_push(), pick_word());
    end
    send_item(rde_pkg::OP_PUSH_BACK, 32'sh7FFF_FFFF);
    send_item(rde_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
    send_item(rde_pkg::OP_REVERSE, '0);
    send_item(rde_pkg::OP_PUSH_BACK, -1);
    send_item(rde_pkg::OP_PUSH_FRONT, '0);
    send_item(3'd7, -1);
    steady = 1'b0;
    hold_until_drained();
  endtask

  // Random traffic in segments of varying push bias so the fill level wanders
  task automatic test_random_traffic(input int item_total);
    int counted;
    int push_bias;
    int r;
    counted = 0;
    push_bias = 50;
    while (counted < item_total) begin
      if (counted % 40 == 0) begin
        case ($urandom_range(2))
          0: push_bias = 15;
          1: push_bias = 50;
          default: push_bias = 85;
        endcase
      end
      steady = (counted >= 400 && counted < 600);
      r = $urandom_range(99);
      if (r < 4) begin
        // unused opcode: ignored, not counted
        send_item(3'($urandom_range(5, 7)), pick_word());
      end else begin
        if (r < 12) send_item(rde_pkg::OP_REVERSE, pick_word());
        else if ($urandom_range(99) < push_bias) send_item(pick_push(), pick_word());
        else send_item(pick_pop(), pick_word());
        counted++;
        if (counted % 300 == 0) hold_until_drained();
      end
    end
    steady = 1'b0;
    hold_until_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_end_order();
    test_full_store();
    test_random_traffic(40);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    deque_reply_t want;
    if (!rst && strobe) begin
      if (pending_replies.size() == 0) begin
        flag_error($sformatf("unexpected result: pop_value=%0d status=%0d",
                             pop_value, status));
      end else begin
        want = pending_replies[0];
        pending_replies.delete(0);
        if (pop_value !== want.word || status !== want.code)
          flag_error($sformatf("mismatch: expected pop_value=%0d status=%0d, got %0d/%0d",
                               want.word, want.code, pop_value, status));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
